[rtl/gimr_pkg.sv]
// Shared types, constants and helper functions for the grid index mixed radix unit.
// No dependencies; every module of the unit imports this package.
package gimr_pkg;

   localparam int NDIM       = 4;
   localparam int DIGIT_W    = 13;
   localparam int ZD_W       = 12;   // zero-based digit
   localparam int WGT_W      = 37;   // largest place weight is 2^36
   localparam int LIN_W      = 48;
   localparam int STEP_W     = 49;
   localparam int TGT_W      = 51;
   localparam int TOT_W      = 49;
   localparam int DIV_STAGES = NDIM * ZD_W;
   localparam logic [DIGIT_W-1:0] MAX_DIM_SIZE = 13'd4096;

   // register indexes on the configuration port
   localparam logic [2:0] REG_DIM_COUNT = 3'd0;
   localparam logic [2:0] REG_SIZE_0    = 3'd1;
   localparam logic [2:0] REG_SIZE_1    = 3'd2;
   localparam logic [2:0] REG_SIZE_2    = 3'd3;
   localparam logic [2:0] REG_SIZE_3    = 3'd4;

   typedef enum logic [2:0] {
      FN_ADD_DIFF  = 3'd0,
      FN_SUB_DIFF  = 3'd1,
      FN_ADD_RHS   = 3'd2,
      FN_SUB_RHS   = 3'd3,
      FN_INC       = 3'd4,
      FN_DEC       = 3'd5,
      FN_TO_LINEAR = 3'd6,
      FN_COMPARE   = 3'd7
   } func_type;

   // one item as it travels through the digit extraction stages
   typedef struct packed {
      logic [LIN_W-1:0]               rem;
      logic [NDIM-1:0][WGT_W-1:0]     wgt;
      logic [NDIM-1:0][ZD_W-1:0]      quo;
      logic [NDIM-1:0][ZD_W-1:0]      pz;
      logic [LIN_W-1:0]               lin;
      logic                           new_pos;
      logic                           oor;
      logic                           greater;
   } div_type;

   function automatic logic [DIGIT_W-1:0] clamp_size(input logic [DIGIT_W-1:0] s);
      logic [DIGIT_W-1:0] r;
      r = s;
      if (r == '0) r = 13'd1;
      if (r > MAX_DIM_SIZE) r = MAX_DIM_SIZE;
      return r;
   endfunction

   function automatic logic [ZD_W-1:0] clamp_zdigit(input logic [DIGIT_W-1:0] raw,
                                                    input logic [DIGIT_W-1:0] size);
      logic [DIGIT_W-1:0] d;
      d = raw;
      if (d == '0) d = 13'd1;
      if (d > size) d = size;
      d = d - 13'd1;
      return d[ZD_W-1:0];
   endfunction

endpackage

[rtl/gimr_front.sv]
// Front stages: clamp inputs, build place weights, linearize, compare, add the signed offset, range check.
// Depends on gimr_pkg.
module gimr_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   en,
   input  logic                                   in_valid,
   input  gimr_pkg::func_type                     in_func,
   input  logic [gimr_pkg::NDIM-1:0][12:0]        in_pos,
   input  logic [gimr_pkg::NDIM-1:0][12:0]        in_other,
   input  logic signed [gimr_pkg::STEP_W-1:0]     in_step,
   input  logic [2:0]                             cfg_dim_count,
   input  logic [gimr_pkg::NDIM-1:0][12:0]        cfg_size,
   output logic                                   out_valid,
   output gimr_pkg::div_type                      out_data
);
   import gimr_pkg::*;

   // stage 1: clamped sizes and zero-based digits
   logic [6:0]                       v_ff;
   func_type                         s1_func_ff;
   logic [NDIM-1:0][DIGIT_W-1:0]     s1_e_ff, s1_e_in;
   logic [NDIM-1:0][ZD_W-1:0]        s1_pz_ff, s1_pz_in, s1_oz_ff, s1_oz_in;
   logic signed [STEP_W-1:0]         s1_step_ff;
   logic [2:0]                       n_dims;
   logic [DIGIT_W-1:0]               sz;

   always_comb begin
      n_dims = cfg_dim_count;
      if (n_dims == 3'd0) n_dims = 3'd1;
      if (n_dims > 3'(NDIM)) n_dims = 3'(NDIM);
      for (int i = 0; i < NDIM; i++) begin
         sz = clamp_size(cfg_size[i]);
         if (3'(i) < n_dims) begin
            s1_e_in[i]  = sz;
            s1_pz_in[i] = clamp_zdigit(in_pos[i], sz);
            s1_oz_in[i] = clamp_zdigit(in_other[i], sz);
         end else begin
            s1_e_in[i]  = 13'd1;
            s1_pz_in[i] = '0;
            s1_oz_in[i] = '0;
         end
      end
   end

   // stage 2: lower weights and the compare
   func_type                         s2_func_ff;
   logic [NDIM-1:0][DIGIT_W-1:0]     s2_e_ff;
   logic [NDIM-1:0][ZD_W-1:0]        s2_pz_ff, s2_oz_ff;
   logic signed [STEP_W-1:0]         s2_step_ff;
   logic                             s2_gt_ff, s2_gt_in, found;
   logic [25:0]                      s2_w1_ff;
   logic [25:0]                      w1_prod;

   always_comb begin
      s2_gt_in = 1'b0;
      found    = 1'b0;
      for (int i = 0; i < NDIM; i++) begin
         if (!found && s1_pz_ff[i] != s1_oz_ff[i]) begin
            found    = 1'b1;
            s2_gt_in = s1_pz_ff[i] > s1_oz_ff[i];
         end
      end
      w1_prod = s1_e_ff[3] * s1_e_ff[2];
   end

   // stage 3: top weight and partial products of the low digits
   func_type                         s3_func_ff;
   logic [DIGIT_W-1:0]               s3_e0_ff;
   logic [NDIM-1:0][ZD_W-1:0]        s3_pz_ff;
   logic [ZD_W-1:0]                  s3_p0_ff, s3_o0_ff;
   logic signed [STEP_W-1:0]         s3_step_ff;
   logic                             s3_gt_ff;
   logic [WGT_W-1:0]                 s3_w0_ff;
   logic [DIGIT_W-1:0]               s3_w2_ff;
   logic [25:0]                      s3_w1_ff;
   logic [LIN_W-1:0]                 s3_plo_ff, s3_olo_ff;
   logic [38:0]                      w0_prod;
   logic [37:0]                      pp1, op1;
   logic [24:0]                      pp2, op2;

   always_comb begin
      w0_prod = s2_w1_ff * s2_e_ff[1];
      pp1 = s2_pz_ff[1] * s2_w1_ff;
      op1 = s2_oz_ff[1] * s2_w1_ff;
      pp2 = s2_pz_ff[2] * s2_e_ff[3];
      op2 = s2_oz_ff[2] * s2_e_ff[3];
   end

   // stage 4: grid total and the top digit product
   func_type                         s4_func_ff;
   logic [NDIM-1:0][ZD_W-1:0]        s4_pz_ff;
   logic signed [STEP_W-1:0]         s4_step_ff;
   logic                             s4_gt_ff;
   logic [NDIM-1:0][WGT_W-1:0]       s4_wgt_ff;
   logic [TOT_W-1:0]                 s4_total_ff;
   logic [LIN_W-1:0]                 s4_plin_ff, s4_olin_ff;
   logic [49:0]                      tot_prod;
   logic [48:0]                      pp0, op0;

   always_comb begin
      tot_prod = s3_w0_ff * s3_e0_ff;
      pp0 = s3_p0_ff * s3_w0_ff;
      op0 = s3_o0_ff * s3_w0_ff;
   end

   // stage 5: signed offset for the move
   func_type                         s5_func_ff;
   logic [NDIM-1:0][ZD_W-1:0]        s5_pz_ff;
   logic                             s5_gt_ff;
   logic [NDIM-1:0][WGT_W-1:0]       s5_wgt_ff;
   logic [TOT_W-1:0]                 s5_total_ff;
   logic [LIN_W-1:0]                 s5_lin_ff;
   logic signed [TGT_W-1:0]          s5_delta_ff, s5_delta_in;
   logic signed [TGT_W-1:0]          step_x, olin_x;

   always_comb begin
      step_x = TGT_W'(s4_step_ff);
      olin_x = signed'({3'b000, s4_olin_ff});
      case (s4_func_ff)
         FN_ADD_DIFF: s5_delta_in = step_x;
         FN_SUB_DIFF: s5_delta_in = -step_x;
         FN_ADD_RHS:  s5_delta_in = olin_x;
         FN_SUB_RHS:  s5_delta_in = -olin_x;
         FN_INC:      s5_delta_in = 51'sd1;
         FN_DEC:      s5_delta_in = -51'sd1;
         default:     s5_delta_in = '0;
      endcase
   end

   // stage 6: target index
   func_type                         s6_func_ff;
   logic [NDIM-1:0][ZD_W-1:0]        s6_pz_ff;
   logic                             s6_gt_ff;
   logic [NDIM-1:0][WGT_W-1:0]       s6_wgt_ff;
   logic [TOT_W-1:0]                 s6_total_ff;
   logic [LIN_W-1:0]                 s6_lin_ff;
   logic signed [TGT_W-1:0]          s6_tgt_ff;

   // stage 7: range check and the remainder handed to the divider
   div_type                          s7_ff, s7_in;
   logic                             is_move, leave;

   always_comb begin
      is_move = (s6_func_ff != FN_TO_LINEAR) && (s6_func_ff != FN_COMPARE);
      leave   = s6_tgt_ff[TGT_W-1] || (s6_tgt_ff[TGT_W-2:0] >= 50'(s6_total_ff));
      s7_in.wgt     = s6_wgt_ff;
      s7_in.quo     = '0;
      s7_in.pz      = s6_pz_ff;
      s7_in.oor     = is_move && leave;
      s7_in.new_pos = is_move && !leave;
      s7_in.greater = (s6_func_ff == FN_COMPARE) && s6_gt_ff;
      s7_in.rem     = s7_in.new_pos ? s6_tgt_ff[LIN_W-1:0] : '0;
      s7_in.lin     = s7_in.new_pos ? s6_tgt_ff[LIN_W-1:0] : s6_lin_ff;
   end

   // advance valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[5:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_func_ff <= in_func;
         s1_e_ff    <= s1_e_in;
         s1_pz_ff   <= s1_pz_in;
         s1_oz_ff   <= s1_oz_in;
         s1_step_ff <= in_step;

         s2_func_ff <= s1_func_ff;
         s2_e_ff    <= s1_e_ff;
         s2_pz_ff   <= s1_pz_ff;
         s2_oz_ff   <= s1_oz_ff;
         s2_step_ff <= s1_step_ff;
         s2_gt_ff   <= s2_gt_in;
         s2_w1_ff   <= w1_prod;

         s3_func_ff <= s2_func_ff;
         s3_e0_ff   <= s2_e_ff[0];
         s3_pz_ff   <= s2_pz_ff;
         s3_p0_ff   <= s2_pz_ff[0];
         s3_o0_ff   <= s2_oz_ff[0];
         s3_step_ff <= s2_step_ff;
         s3_gt_ff   <= s2_gt_ff;
         s3_w0_ff   <= w0_prod[WGT_W-1:0];
         s3_w1_ff   <= s2_w1_ff;
         s3_w2_ff   <= s2_e_ff[3];
         s3_plo_ff  <= LIN_W'(pp1) + LIN_W'(pp2) + LIN_W'(s2_pz_ff[3]);
         s3_olo_ff  <= LIN_W'(op1) + LIN_W'(op2) + LIN_W'(s2_oz_ff[3]);

         // weight of digit i lands at index i, digit 0 first
         s4_func_ff  <= s3_func_ff;
         s4_pz_ff    <= s3_pz_ff;
         s4_step_ff  <= s3_step_ff;
         s4_gt_ff    <= s3_gt_ff;
         s4_wgt_ff   <= {WGT_W'(1), WGT_W'(s3_w2_ff), WGT_W'(s3_w1_ff), s3_w0_ff};
         s4_total_ff <= tot_prod[TOT_W-1:0];
         s4_plin_ff  <= pp0[LIN_W-1:0] + s3_plo_ff;
         s4_olin_ff  <= op0[LIN_W-1:0] + s3_olo_ff;

         s5_func_ff  <= s4_func_ff;
         s5_pz_ff    <= s4_pz_ff;
         s5_gt_ff    <= s4_gt_ff;
         s5_wgt_ff   <= s4_wgt_ff;
         s5_total_ff <= s4_total_ff;
         s5_lin_ff   <= s4_plin_ff;
         s5_delta_ff <= s5_delta_in;

         s6_func_ff  <= s5_func_ff;
         s6_pz_ff    <= s5_pz_ff;
         s6_gt_ff    <= s5_gt_ff;
         s6_wgt_ff   <= s5_wgt_ff;
         s6_total_ff <= s5_total_ff;
         s6_lin_ff   <= s5_lin_ff;
         s6_tgt_ff   <= signed'({3'b000, s5_lin_ff}) + s5_delta_ff;

         s7_ff <= s7_in;
      end
   end

   assign out_valid = v_ff[6];
   assign out_data  = s7_ff;

endmodule

[rtl/gimr_divider.sv]
// Digit extraction: one restoring quotient bit per stage, twelve stages per digit.
// Depends on gimr_pkg.
module gimr_divider (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  gimr_pkg::div_type   in_data,
   output logic                out_valid,
   output gimr_pkg::div_type   out_data
);
   import gimr_pkg::*;

   logic [DIV_STAGES-1:0] v_ff;
   div_type               stg_ff [DIV_STAGES];
   div_type               stg_in [DIV_STAGES];

   // advance valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[DIV_STAGES-2:0], in_valid};
      end
   end

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      localparam int DI = s / ZD_W;
      localparam int BI = ZD_W - 1 - (s % ZD_W);
      div_type        src;
      logic [48:0]    cand;

      if (s == 0) begin : g_first
         assign src = in_data;
      end else begin : g_next
         assign src = stg_ff[s-1];
      end

      // subtract the shifted weight where it fits and set the quotient bit
      always_comb begin
         stg_in[s] = src;
         cand = 49'(src.wgt[DI]) << BI;
         if ({1'b0, src.rem} >= cand) begin
            stg_in[s].rem         = src.rem - cand[LIN_W-1:0];
            stg_in[s].quo[DI][BI] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            stg_ff[s] <= stg_in[s];
         end
      end
   end

   assign out_valid = v_ff[DIV_STAGES-1];
   assign out_data  = stg_ff[DIV_STAGES-1];

endmodule

[rtl/grid_index_mixed_radix_unit.sv]
// Top level of the grid index mixed radix unit: stream ports, register file, output stage.
// Depends on gimr_pkg, gimr_front and gimr_divider.
//
//   channel   ports     direction   carries
//   req_*     stream    in          one operation and its operands per item
//   rsp_*     stream    out         one result item per request item
//   csr_*     APB       in/out      dimension count and dimension sizes
//
// One item enters per cycle while no result waits on rsp_tready; the path is 7 front stages,
// 48 quotient-bit stages of the digit extractor and one output register.
// The digit extractor's one-bit-per-stage subtract sets the depth.
// Reset clears valid bits and loads the register reset values.
// A waiting result holds the whole pipeline; nothing is dropped or repeated.
module grid_index_mixed_radix_unit (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // func
   input  logic [2:0]    req_tuser,
   // pos_digit_0..3, other_digit_0..3, step_amount, zero fill
   input  logic [159:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // res_digit_0..3, linear_index, out_of_range, greater, zero fill
   output logic [103:0]  rsp_tdata,
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [4:0]    csr_paddr,
   input  logic [31:0]   csr_pwdata,
   output logic [31:0]   csr_prdata,
   output logic          csr_pready
);
   import gimr_pkg::*;

   // configuration registers
   logic [2:0]                    dim_count_ff;
   logic [NDIM-1:0][DIGIT_W-1:0]  dim_size_ff;
   logic                          csr_wr;
   logic [2:0]                    csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_count_ff <= 3'd3;
         dim_size_ff  <= {NDIM{13'd1}};
      end else if (csr_wr) begin
         case (csr_idx)
            REG_DIM_COUNT: dim_count_ff   <= csr_pwdata[2:0];
            REG_SIZE_0:    dim_size_ff[0] <= csr_pwdata[DIGIT_W-1:0];
            REG_SIZE_1:    dim_size_ff[1] <= csr_pwdata[DIGIT_W-1:0];
            REG_SIZE_2:    dim_size_ff[2] <= csr_pwdata[DIGIT_W-1:0];
            REG_SIZE_3:    dim_size_ff[3] <= csr_pwdata[DIGIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_DIM_COUNT: csr_prdata = {29'd0, dim_count_ff};
         REG_SIZE_0:    csr_prdata = {19'd0, dim_size_ff[0]};
         REG_SIZE_1:    csr_prdata = {19'd0, dim_size_ff[1]};
         REG_SIZE_2:    csr_prdata = {19'd0, dim_size_ff[2]};
         REG_SIZE_3:    csr_prdata = {19'd0, dim_size_ff[3]};
         default:       csr_prdata = '0;
      endcase
   end

   // hold the pipeline while a result waits
   logic                          en;
   logic                          out_valid_ff;
   assign en         = !out_valid_ff || rsp_tready;
   assign req_tready = en;

   // unpack the request
   logic [NDIM-1:0][DIGIT_W-1:0]  pos, other;
   logic signed [STEP_W-1:0]      step;
   assign pos   = req_tdata[51:0];
   assign other = req_tdata[103:52];
   assign step  = signed'(req_tdata[152:104]);

   logic     f_valid, d_valid;
   div_type  f_data, d_data;

   gimr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .in_valid      (req_tvalid),
      .in_func       (func_type'(req_tuser)),
      .in_pos        (pos),
      .in_other      (other),
      .in_step       (step),
      .cfg_dim_count (dim_count_ff),
      .cfg_size      (dim_size_ff),
      .out_valid     (f_valid),
      .out_data      (f_data)
   );

   gimr_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .in_data   (f_data),
      .out_valid (d_valid),
      .out_data  (d_data)
   );

   // pick new or original digits and register the result item
   logic [103:0] rsp_in;
   logic [103:0] rsp_ff;

   always_comb begin
      rsp_in = '0;
      for (int i = 0; i < NDIM; i++) begin
         rsp_in[i*DIGIT_W +: DIGIT_W] = d_data.new_pos ? DIGIT_W'(d_data.quo[i]) + 13'd1
                                                       : DIGIT_W'(d_data.pz[i]) + 13'd1;
      end
      rsp_in[99:52] = d_data.lin;
      rsp_in[100]   = d_data.oor;
      rsp_in[101]   = d_data.greater;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= d_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = rsp_ff;

endmodule
